/* design/rzt_pkg.sv */
// rzt_pkg: shared types and constants for the RSSI zone tracker.
// No dependencies.
`default_nettype none
package rzt_pkg;
  localparam int DEVICE_SLOTS = 16;
  localparam logic [2:0] ZONE_UNKNOWN = 3'd4;
  localparam logic [1:0] ZONE_FAR = 2'd3;
  localparam logic [2:0] REG_INTIMATE = 3'd0;
  localparam logic [2:0] REG_CLOSE = 3'd1;
  localparam logic [2:0] REG_NEARBY = 3'd2;
  localparam logic [2:0] REG_WINDOW = 3'd3;
  localparam logic [2:0] REG_HYST = 3'd4;
  localparam logic signed [7:0] BARS4_LEVEL = -8'sd55;
  localparam logic signed [7:0] BARS3_LEVEL = -8'sd70;
  localparam logic signed [7:0] BARS2_LEVEL = -8'sd85;
  localparam int SPREAD_FULL = 30;
  localparam int SPREAD_STABLE = 10;

  // One input item as it crosses the front-to-back queue.
  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [7:0]  sample;
    logic [31:0] now;
  } item_t;

  // Confidence for a spread: floor((30 - spread) * 256 / 30), zero from 30 up.
  // 256/30 is taken as 2185/256, exact after flooring for spreads 0..29.
  function automatic logic [8:0] conf_of(input logic [8:0] spread);
    logic [16:0] prod;
    logic [8:0] r;
    prod = 17'd0;
    r = 9'd0;
    if (spread < 9'(SPREAD_FULL)) begin
      prod = 17'(9'(SPREAD_FULL) - spread) * 17'd2185;
      r = prod[16:8];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

/* design/rzt_ram.sv */
// rzt_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module rzt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 320
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/rzt_front.sv */
// rzt_front: accepts input items, drops bad slots, queues the rest.
// Depends on rzt_pkg.
`default_nettype none
module rzt_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  output logic             full,
  input  wire              kind,
  input  wire [3:0]        device_slot,
  input  wire [7:0]        rssi_sample,
  input  wire [31:0]       time_now,
  output logic             q_valid,
  output rzt_pkg::item_t   q_item,
  input  wire              q_take
);
  // Two-entry queue.
  rzt_pkg::item_t buf0, buf1;
  logic [1:0] fill;
  logic acc, keep;

  assign full = (fill == 2'd2);
  assign acc = push && !full;
  assign keep = acc && (32'(device_slot) < 32'(rzt_pkg::DEVICE_SLOTS));
  assign q_valid = (fill != 2'd0);
  assign q_item = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      unique case ({keep, q_take && q_valid})
        2'b10: fill <= fill + 2'd1;
        2'b01: fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_take && q_valid) begin
      buf0 <= buf1;
      if (keep && fill == 2'd1) buf0 <= {kind, device_slot, rssi_sample, time_now};
      if (keep && fill == 2'd2) buf1 <= {kind, device_slot, rssi_sample, time_now};
    end else if (keep) begin
      if (fill == 2'd0) buf0 <= {kind, device_slot, rssi_sample, time_now};
      else buf1 <= {kind, device_slot, rssi_sample, time_now};
    end
  end
endmodule
`default_nettype wire

/* design/rzt_back.sv */
// rzt_back: per-slot history walk, averaging, zoning and hysteresis.
// Depends on rzt_pkg and rzt_ram.
`default_nettype none
module rzt_back #(
  parameter int MAX_WINDOW = 20
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                q_valid,
  input  rzt_pkg::item_t     q_item,
  output logic               q_take,
  input  wire signed [7:0]   thr_intimate,
  input  wire signed [7:0]   thr_close,
  input  wire signed [7:0]   thr_nearby,
  input  wire [4:0]          window_length,
  input  wire [31:0]         hysteresis_time,
  output logic               empty,
  input  wire                pop,
  output logic signed [7:0]  smoothed_rssi,
  output logic [1:0]         zone,
  output logic [2:0]         bar_count,
  output logic [8:0]         confidence,
  output logic               stable,
  output logic               zone_changed,
  output logic [2:0]         prior_zone,
  output logic               moving_closer,
  output logic               security_alert
);
  localparam int SW = (rzt_pkg::DEVICE_SLOTS > 1) ? $clog2(rzt_pkg::DEVICE_SLOTS) : 1;
  localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int DEPTH = rzt_pkg::DEVICE_SLOTS * MAX_WINDOW;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUMW = 8 + CW + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // Per-slot state in flip-flops.
  logic [CW-1:0] cnt_r [rzt_pkg::DEVICE_SLOTS];
  logic [PW-1:0] head_r [rzt_pkg::DEVICE_SLOTS];
  logic [2:0]    azone_r [rzt_pkg::DEVICE_SLOTS];
  logic [31:0]   ltime_r [rzt_pkg::DEVICE_SLOTS];
  logic          ever_r [rzt_pkg::DEVICE_SLOTS];
  logic [8:0]    hconf_r [rzt_pkg::DEVICE_SLOTS];
  logic          hstab_r [rzt_pkg::DEVICE_SLOTS];

  logic [2:0] state;
  rzt_pkg::item_t it;
  logic [SW-1:0] sl;
  logic [CW-1:0] w, n, k, rdcnt;
  logic [PW-1:0] rpos;
  logic signed [SUMW-1:0] sum;
  logic signed [8:0] mn, mx;
  logic [SUMW-1:0] rem, mag, quo;
  logic [4:0] dstep;
  logic neg;
  logic [CW:0] wtmp;

  // History RAM; the new reading is written in the first walk cycle so the
  // read of the newest entry, issued in the next cycle, already sees it.
  logic ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [7:0] ram_rd;
  rzt_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_hist (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(it.sample),
    .raddr(ram_ra), .rdata(ram_rd)
  );
  assign ram_ra = AW'(32'(sl) * MAX_WINDOW + 32'(rpos));
  assign ram_we = (state == ST_WALK) && (k == '0) && !it.kind;
  assign ram_wa = AW'(32'(sl) * MAX_WINDOW + 32'(head_r[sl]));

  assign sl = it.slot[SW-1:0];
  assign q_take = (state == ST_IDLE) && q_valid;
  assign empty = (state != ST_OUT);

  always_comb begin
    wtmp = (CW+1)'(window_length);
    if (wtmp == '0) wtmp = (CW+1)'(1);
    if (wtmp > (CW+1)'(MAX_WINDOW)) wtmp = (CW+1)'(MAX_WINDOW);
  end

  // Final classification of the quotient.
  logic signed [7:0] avg;
  logic [1:0] zn;
  logic [2:0] bars;
  logic [8:0] spread;
  logic [31:0] elapsed;
  logic do_chg;
  assign avg = neg ? -8'(quo) : 8'(quo);
  always_comb begin
    priority if (avg >= thr_intimate) zn = 2'd0;
    else if (avg >= thr_close) zn = 2'd1;
    else if (avg >= thr_nearby) zn = 2'd2;
    else zn = rzt_pkg::ZONE_FAR;
    priority if (avg >= rzt_pkg::BARS4_LEVEL) bars = 3'd4;
    else if (avg >= rzt_pkg::BARS3_LEVEL) bars = 3'd3;
    else if (avg >= rzt_pkg::BARS2_LEVEL) bars = 3'd2;
    else bars = 3'd1;
  end
  assign spread = 9'(mx - mn);
  assign elapsed = it.now - ltime_r[sl];
  assign do_chg = ({1'b0, zn} != azone_r[sl]) &&
                  (!ever_r[sl] || elapsed >= hysteresis_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int s = 0; s < rzt_pkg::DEVICE_SLOTS; s++) begin
        cnt_r[s] <= '0; head_r[s] <= '0; azone_r[s] <= rzt_pkg::ZONE_UNKNOWN;
        ltime_r[s] <= '0; ever_r[s] <= 1'b0; hconf_r[s] <= '0; hstab_r[s] <= 1'b0;
      end
    end else begin
      unique case (state)
        ST_IDLE: if (q_valid) begin
          it <= q_item;
          state <= ST_WALK;
          k <= '0;
          rdcnt <= '0;
        end
        ST_WALK: begin
          if (k == '0) begin
            // Kick: remove or append, set up the walk.
            if (it.kind) begin
              cnt_r[sl] <= '0; head_r[sl] <= '0; azone_r[sl] <= rzt_pkg::ZONE_UNKNOWN;
              ltime_r[sl] <= '0; ever_r[sl] <= 1'b0; hconf_r[sl] <= '0;
              hstab_r[sl] <= 1'b0;
              state <= ST_IDLE;
            end else begin
              head_r[sl] <= (32'(head_r[sl]) == MAX_WINDOW - 1) ? '0 : head_r[sl] + 1'b1;
              w <= CW'(wtmp);
              if (32'(cnt_r[sl]) + 1 > 32'(wtmp)) n <= CW'(wtmp);
              else n <= cnt_r[sl] + 1'b1;
              if (32'(cnt_r[sl]) + 1 > 32'(wtmp)) cnt_r[sl] <= CW'(wtmp);
              else cnt_r[sl] <= cnt_r[sl] + 1'b1;
              rpos <= head_r[sl];
              sum <= '0; mn <= 9'sd127; mx <= -9'sd128;
              k <= k + 1'b1;
            end
          end else begin
            // One read issued per cycle, newest first; data arrives in the next cycle.
            if (k <= n) begin
              rpos <= (rpos == '0) ? PW'(MAX_WINDOW - 1) : rpos - 1'b1;
              k <= k + 1'b1;
            end
            if (k >= 2 && rdcnt < n) begin
              sum <= sum + SUMW'($signed(ram_rd));
              if ($signed({ram_rd[7], ram_rd}) < mn) mn <= $signed({ram_rd[7], ram_rd});
              if ($signed({ram_rd[7], ram_rd}) > mx) mx <= $signed({ram_rd[7], ram_rd});
              rdcnt <= rdcnt + 1'b1;
              if (rdcnt + 1'b1 == n) begin
                state <= ST_DIV;
                dstep <= 5'(SUMW);
                rem <= '0;
              end
            end
          end
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (dstep == 5'(SUMW)) begin
            neg <= sum[SUMW-1];
            mag <= sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
            quo <= '0;
            rem <= '0;
            dstep <= dstep - 1'b1;
          end else begin
            if ({rem[SUMW-2:0], mag[SUMW-1]} >= SUMW'(n)) begin
              rem <= {rem[SUMW-2:0], mag[SUMW-1]} - SUMW'(n);
              quo <= {quo[SUMW-2:0], 1'b1};
            end else begin
              rem <= {rem[SUMW-2:0], mag[SUMW-1]};
              quo <= {quo[SUMW-2:0], 1'b0};
            end
            mag <= {mag[SUMW-2:0], 1'b0};
            if (dstep == '0) state <= ST_FIN;
            else dstep <= dstep - 1'b1;
          end
        end
        ST_FIN: begin
          smoothed_rssi <= avg;
          zone <= zn;
          bar_count <= bars;
          if (n >= w) begin
            hconf_r[sl] <= rzt_pkg::conf_of(spread);
            hstab_r[sl] <= (spread < 9'(rzt_pkg::SPREAD_STABLE));
            confidence <= rzt_pkg::conf_of(spread);
            stable <= (spread < 9'(rzt_pkg::SPREAD_STABLE));
          end else begin
            confidence <= hconf_r[sl];
            stable <= hstab_r[sl];
          end
          zone_changed <= do_chg;
          prior_zone <= do_chg ? azone_r[sl] : rzt_pkg::ZONE_UNKNOWN;
          moving_closer <= do_chg && ({1'b0, zn} < azone_r[sl]);
          security_alert <= do_chg && (azone_r[sl] != rzt_pkg::ZONE_UNKNOWN) &&
                            (zn == rzt_pkg::ZONE_FAR) &&
                            (azone_r[sl] != {1'b0, rzt_pkg::ZONE_FAR});
          if (do_chg) begin
            azone_r[sl] <= {1'b0, zn};
            ltime_r[sl] <= it.now;
            ever_r[sl] <= 1'b1;
          end
          state <= ST_OUT;
        end
        ST_OUT: if (pop) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* design/rssi_zone_tracker.sv */
// rssi_zone_tracker: top level, configuration registers, front and back.
// Depends on rzt_pkg, rzt_front, rzt_back, rzt_ram.
//
// Usage: input items are pushed with push while full is low; a two-entry
// queue in the front holds them. Feed items (kind 0) give one result each,
// remove items (kind 1) and items with a slot out of range give none.
// Results appear while empty is low and leave on pop; the result register
// holds until popped, while the front keeps taking items into its queue.
// Path from the input transfer to empty going low, window of n readings:
// the front queue register, the take into the back, the history walk (one
// read per reading, newest first), the bit-serial divide and the finish
// step, paced by the single history RAM read port and the divider. One item
// at a time in the back: a reading holds it until popped, a remove does not.
// A stalled receiver holds the back; the front queue then fills and full rises.
// Configuration writes (cfg_valid/cfg_ready, always ready) update the
// thresholds, window length and hysteresis time; write them only when idle.
// Reset (rst, synchronous) clears all slot state and restores the register
// defaults; history RAM contents are undefined until written.
`default_nettype none
module rssi_zone_tracker #(
  parameter int MAX_WINDOW = 20
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  output logic              full,
  input  wire               kind,
  input  wire [3:0]         device_slot,
  input  wire [7:0]         rssi_sample,
  input  wire [31:0]        time_now,
  output logic              empty,
  input  wire               pop,
  output logic signed [7:0] smoothed_rssi,
  output logic [1:0]        zone,
  output logic [2:0]        bar_count,
  output logic [8:0]        confidence,
  output logic              stable,
  output logic              zone_changed,
  output logic [2:0]        prior_zone,
  output logic              moving_closer,
  output logic              security_alert,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [2:0]         cfg_index,
  input  wire [31:0]        cfg_data
);
  logic signed [7:0] thr_i, thr_c, thr_n;
  logic [4:0] win;
  logic [31:0] hyst;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_i <= -8'sd68; thr_c <= -8'sd79; thr_n <= -8'sd88;
      win <= 5'd5; hyst <= 32'd2000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rzt_pkg::REG_INTIMATE: thr_i <= cfg_data[7:0];
        rzt_pkg::REG_CLOSE:    thr_c <= cfg_data[7:0];
        rzt_pkg::REG_NEARBY:   thr_n <= cfg_data[7:0];
        rzt_pkg::REG_WINDOW:   win <= cfg_data[4:0];
        rzt_pkg::REG_HYST:     hyst <= cfg_data;
        default: ;
      endcase
    end
  end

  logic q_valid, q_take;
  rzt_pkg::item_t q_item;

  rzt_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind),
    .device_slot(device_slot), .rssi_sample(rssi_sample), .time_now(time_now),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
  );

  rzt_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
    .thr_intimate(thr_i), .thr_close(thr_c), .thr_nearby(thr_n),
    .window_length(win), .hysteresis_time(hyst),
    .empty(empty), .pop(pop), .smoothed_rssi(smoothed_rssi), .zone(zone),
    .bar_count(bar_count), .confidence(confidence), .stable(stable),
    .zone_changed(zone_changed), .prior_zone(prior_zone),
    .moving_closer(moving_closer), .security_alert(security_alert)
  );
endmodule
`default_nettype wire
